@@ hdl/rcs_pkg.sv @@
package rcs_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned AW        = $clog2(MEM_BYTES);
  localparam int unsigned ROWS      = MEM_BYTES / 4;
  localparam int unsigned RW        = AW - 2;
  localparam int unsigned RIW       = $clog2(NUM_REGS);

  localparam logic [15:0] CODE_BASE_RST = 16'd4096;
  localparam logic [15:0] TRAP_VEC_RST  = 16'd0;

  localparam logic [6:0] OPC_IMM    = 7'((8'h04 << 2) + 8'h03);
  localparam logic [6:0] OPC_REG    = 7'((8'h0C << 2) + 8'h03);
  localparam logic [6:0] OPC_JALR   = 7'((8'h19 << 2) + 8'h03);
  localparam logic [6:0] OPC_JAL    = 7'((8'h1B << 2) + 8'h03);
  localparam logic [6:0] OPC_LUI    = 7'((8'h0D << 2) + 8'h03);
  localparam logic [6:0] OPC_BRANCH = 7'((8'h18 << 2) + 8'h03);
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'((8'h08 << 2) + 8'h03);
  localparam logic [6:0] OPC_HALT   = 7'h7F;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  localparam logic [1:0] CFG_CODE_BASE = 2'd0;
  localparam logic [1:0] CFG_TRAP_VEC  = 2'd1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [RIW-1:0] HALT_LINK_REG = RIW'(8);

  typedef struct packed {
    logic          en;
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   data;
    logic [1:0]    size;
  } mem_req_t;

  typedef struct packed {
    logic           we;
    logic [RIW-1:0] idx;
    logic [31:0]    data;
  } rf_wr_t;

  typedef struct packed {
    logic           ok;
    logic           wr;
    logic [RIW-1:0] rdi;
    logic [31:0]    res;
    logic [31:0]    next_pc;
    logic           is_load;
    logic           is_store;
    logic [2:0]     f3;
    logic [31:0]    maddr;
  } exec_t;

  typedef struct packed {
    logic [31:0]    retired_count;
    logic [31:0]    rd_value;
    logic [RIW-1:0] rd_index;
    logic           rd_written;
    logic           illegal;
    logic           halted;
    logic [31:0]    pc_value;
    logic [31:0]    read_data;
  } result_t;

endpackage

@@ hdl/rcs_bmem.sv @@
module rcs_bmem
  import rcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mem_req_t    req_i,
  output logic [31:0] rd_data_o,
  output logic        busy_o
);

  logic          clr_q, clr_d;
  logic [RW-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]    a0_q;
  logic [7:0]    bank_rd [4];

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + RW'(1);
      if (clr_cnt_q == RW'(ROWS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      a0_q <= req_i.addr[1:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    off;
    logic [AW-1:0] baddr;
    logic [RW-1:0] row;
    logic          wen;
    logic [7:0]    wbyte;

    always_comb begin
      off   = 2'(k) - req_i.addr[1:0];
      baddr = req_i.addr + AW'(off);
      row   = baddr[AW-1:2];
      wen   = (req_i.size == SIZE_WORD) || (req_i.size == SIZE_HALF && off < 2'd2)
              || (off == 2'd0);
      wbyte = req_i.data[8*off +: 8];
    end

    always_ff @(posedge clk_i) begin
      if (clr_q) begin
        mem[clr_cnt_q] <= 8'h00;
      end else if (req_i.en && req_i.we && wen) begin
        mem[row] <= wbyte;
      end
      if (req_i.en && !req_i.we) begin
        bank_rd[k] <= mem[row];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_data_o[8*i +: 8] = bank_rd[2'(a0_q + 2'(i))];
    end
  end

  assign busy_o = clr_q;

endmodule

@@ hdl/rcs_rf.sv @@
module rcs_rf
  import rcs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  logic [RIW-1:0] rs1_i,
  input  logic [RIW-1:0] rs2_i,
  input  rf_wr_t         wr_i,
  output logic [31:0]    rd1_o,
  output logic [31:0]    rd2_o,
  output logic           busy_o
);

  logic [31:0]    regs [NUM_REGS];
  logic           clr_q;
  logic [RIW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + RIW'(1);
      if (clr_cnt_q == RIW'(NUM_REGS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      regs[clr_cnt_q] <= '0;
    end else if (wr_i.we && wr_i.idx != '0) begin
      regs[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd1_o <= regs[rs1_i];
      rd2_o <= regs[rs2_i];
    end
  end

  assign busy_o = clr_q;

endmodule

@@ hdl/rcs_exec.sv @@
module rcs_exec
  import rcs_pkg::*;
(
  input  logic [31:0] ins_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] pc_i,
  input  logic [15:0] trap_i,
  output exec_t       ex_o
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic        alt;
  logic        is_reg;
  logic [31:0] immi, imms, immj, immb, opb, alu_res, pc4;
  logic        alu_ok, take;

  always_comb begin
    opc    = ins_i[6:0];
    f3     = ins_i[14:12];
    alt    = ins_i[31:25] != 7'd0;
    is_reg = opc == OPC_REG;
    immi   = {{20{ins_i[31]}}, ins_i[31:20]};
    imms   = {{20{ins_i[31]}}, ins_i[31:25], ins_i[11:7]};
    immj   = {{11{ins_i[31]}}, ins_i[31], ins_i[19:12], ins_i[20], ins_i[30:21], 1'b0};
    immb   = {{19{ins_i[31]}}, ins_i[31], ins_i[7], ins_i[30:25], ins_i[11:8], 1'b0};
    pc4    = pc_i + 32'd4;
    if (is_reg) begin
      opb = b_i;
    end else if (f3 == 3'd1 || f3 == 3'd5) begin
      opb = {27'd0, ins_i[24:20]};
    end else begin
      opb = immi;
    end

    alu_ok = 1'b1;
    case (f3)
      3'd0:    alu_res = (is_reg && alt) ? a_i - opb : a_i + opb;
      3'd1:    alu_res = a_i << opb[4:0];
      3'd4:    alu_res = a_i ^ opb;
      3'd5:    alu_res = alt ? 32'($signed(a_i) >>> opb[4:0]) : a_i >> opb[4:0];
      3'd6:    alu_res = a_i | opb;
      3'd7:    alu_res = a_i & opb;
      default: begin
        alu_res = '0;
        alu_ok  = 1'b0;
      end
    endcase

    case (f3)
      3'd0:    take = a_i == b_i;
      3'd1:    take = a_i != b_i;
      3'd4:    take = $signed(a_i) < $signed(b_i);
      default: take = $signed(a_i) >= $signed(b_i);
    endcase

    ex_o          = '0;
    ex_o.ok       = 1'b1;
    ex_o.rdi      = ins_i[11:7];
    ex_o.next_pc  = pc4;
    ex_o.f3       = f3;
    ex_o.maddr    = a_i + immi;
    case (opc)
      OPC_IMM, OPC_REG: begin
        ex_o.ok  = alu_ok;
        ex_o.wr  = 1'b1;
        ex_o.res = alu_res;
      end
      OPC_LUI: begin
        ex_o.wr  = 1'b1;
        ex_o.res = {ins_i[31:12], 12'd0};
      end
      OPC_JAL: begin
        ex_o.wr      = 1'b1;
        ex_o.res     = pc4;
        ex_o.next_pc = pc_i + immj;
      end
      OPC_JALR: begin
        ex_o.wr      = 1'b1;
        ex_o.res     = pc4;
        ex_o.next_pc = (a_i + immi) & ~32'd1;
      end
      OPC_BRANCH: begin
        ex_o.ok = f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd5;
        if (take) begin
          ex_o.next_pc = pc_i + immb;
        end
      end
      OPC_LOAD: begin
        ex_o.ok      = f3 <= 3'd2;
        ex_o.wr      = 1'b1;
        ex_o.is_load = 1'b1;
      end
      OPC_STORE: begin
        ex_o.ok       = f3 <= 3'd2;
        ex_o.is_store = 1'b1;
        ex_o.maddr    = a_i + imms;
      end
      OPC_HALT: begin
        ex_o.wr      = 1'b1;
        ex_o.rdi     = HALT_LINK_REG;
        ex_o.res     = pc_i;
        ex_o.next_pc = {16'd0, trap_i};
      end
      default: ex_o.ok = 1'b0;
    endcase
    ex_o.wr = ex_o.wr && ex_o.ok && ex_o.rdi != '0;
  end

endmodule

@@ hdl/rv32i_subset_core_step_top.sv @@
// Timing: a word write, an unused request, or an execute while halted or at the trap vector
// gives its result in the cycle after acceptance; a word read passes through S_HREAD, an
// instruction through S_FETCH and S_EXEC, and a load also through S_LOAD before its result.
// A new item is accepted only in S_IDLE, so one item is finished before the next is taken.
// Reset: the byte memory is cleared one row of four bytes per cycle, during which no item
// is accepted; configuration writes are taken throughout.
module rv32i_subset_core_step_top
  import rcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mem_addr[15:0], mem_data[47:16]
  input  logic [47:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_data, pc_value, halted, illegal, rd_written, rd_index, rd_value, retired_count
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_LOAD, S_HREAD
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] pc_q, pc_d, count_q, count_d, ins_q, ins_d;
  logic        halt_q, halt_d, illegal_q, illegal_d;
  logic [15:0] code_base_q, code_base_d, trap_q, trap_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, res_d;
  logic        done;

  mem_req_t    mreq;
  logic [31:0] mrd;
  logic        mbusy, rbusy;
  logic        rf_rd;
  rf_wr_t      rfw;
  logic [31:0] ra, rb, host_addr, ldv;
  exec_t       ex;

  rcs_bmem u_bmem (
    .clk_i, .rst_ni, .req_i(mreq), .rd_data_o(mrd), .busy_o(mbusy)
  );

  rcs_rf u_rf (
    .clk_i, .rst_ni, .rd_en_i(rf_rd), .rs1_i(mrd[19:15]), .rs2_i(mrd[24:20]),
    .wr_i(rfw), .rd1_o(ra), .rd2_o(rb), .busy_o(rbusy)
  );

  rcs_exec u_exec (
    .ins_i(ins_q), .a_i(ra), .b_i(rb), .pc_i(pc_q), .trap_i(trap_q), .ex_o(ex)
  );

  assign s_axis_tready = state_q == S_IDLE && !mbusy && !rbusy
                         && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign host_addr     = {16'd0, s_axis_tdata[15:0]};

  always_comb begin
    case (ins_q[13:12])
      2'd0:    ldv = {{24{mrd[7]}}, mrd[7:0]};
      2'd1:    ldv = {{16{mrd[15]}}, mrd[15:0]};
      default: ldv = mrd;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    count_d     = count_q;
    ins_d       = ins_q;
    halt_d      = halt_q;
    illegal_d   = illegal_q;
    code_base_d = code_base_q;
    trap_d      = trap_q;
    mreq        = '0;
    rf_rd       = 1'b0;
    rfw         = '0;
    done        = 1'b0;
    res_d       = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (s_axis_tuser)
            REQ_WRITE: begin
              mreq.en   = 1'b1;
              mreq.we   = 1'b1;
              mreq.addr = host_addr[AW-1:0];
              mreq.data = s_axis_tdata[47:16];
              mreq.size = SIZE_WORD;
              done      = 1'b1;
            end
            REQ_READ: begin
              mreq.en   = 1'b1;
              mreq.addr = host_addr[AW-1:0];
              state_d   = S_HREAD;
            end
            REQ_EXEC: begin
              if (halt_q) begin
                done = 1'b1;
              end else if (pc_q == {16'd0, trap_q}) begin
                halt_d = 1'b1;
                done   = 1'b1;
              end else begin
                mreq.en   = 1'b1;
                mreq.addr = pc_q[AW-1:0];
                state_d   = S_FETCH;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_HREAD: begin
        res_d.read_data = mrd;
        done            = 1'b1;
        state_d         = S_IDLE;
      end
      S_FETCH: begin
        ins_d   = mrd;
        rf_rd   = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!ex.ok) begin
          halt_d    = 1'b1;
          illegal_d = 1'b1;
          done      = 1'b1;
          state_d   = S_IDLE;
        end else if (ex.is_load) begin
          mreq.en   = 1'b1;
          mreq.addr = ex.maddr[AW-1:0];
          state_d   = S_LOAD;
        end else begin
          if (ex.is_store) begin
            mreq.en   = 1'b1;
            mreq.we   = 1'b1;
            mreq.addr = ex.maddr[AW-1:0];
            mreq.data = rb;
            mreq.size = ex.f3[1:0];
          end
          rfw.we           = ex.wr;
          rfw.idx          = ex.rdi;
          rfw.data         = ex.res;
          res_d.rd_written = ex.wr;
          res_d.rd_index   = ex.wr ? ex.rdi : '0;
          res_d.rd_value   = ex.wr ? ex.res : '0;
          pc_d             = ex.next_pc;
          count_d          = count_q + 32'd1;
          done             = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_LOAD: begin
        rfw.we           = ex.wr;
        rfw.idx          = ex.rdi;
        rfw.data         = ldv;
        res_d.rd_written = ex.wr;
        res_d.rd_index   = ex.wr ? ex.rdi : '0;
        res_d.rd_value   = ex.wr ? ldv : '0;
        pc_d             = ex.next_pc;
        count_d          = count_q + 32'd1;
        done             = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CODE_BASE) begin
        code_base_d = cfg_data_i;
        pc_d        = {16'd0, cfg_data_i};
      end else if (cfg_index_i == CFG_TRAP_VEC) begin
        trap_d = cfg_data_i;
      end
    end

    res_d.pc_value      = pc_d;
    res_d.halted        = halt_d;
    res_d.illegal       = illegal_d;
    res_d.retired_count = count_d;
    out_valid_d         = done || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= {16'd0, CODE_BASE_RST};
      count_q     <= '0;
      halt_q      <= 1'b0;
      illegal_q   <= 1'b0;
      code_base_q <= CODE_BASE_RST;
      trap_q      <= TRAP_VEC_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      count_q     <= count_d;
      halt_q      <= halt_d;
      illegal_q   <= illegal_d;
      code_base_q <= code_base_d;
      trap_q      <= trap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    if (done) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_illegal_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    illegal_q |-> halt_q)
    else $error("illegal flag set without halt flag");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared outside reset");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + 32'd1)
    else $error("retire counter moved by more than one");

endmodule

@@ tb/sv/rv32i_subset_core_step_top_test.sv @@
module rv32i_subset_core_step_top_test;
  import rcs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 60000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [31:0] data;
    int unsigned gap;
  } pend_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  rv32i_subset_core_step_top dut (.*);

  // Shadow core state.
  logic [7:0]  shadow_mem [0:65535];
  logic [31:0] shadow_regs [0:31];
  logic [31:0] shadow_pc;
  bit          shadow_halt, shadow_illegal;
  logic [31:0] shadow_retired;
  logic [15:0] shadow_base, shadow_trap;

  pend_t   stim_q [$];
  result_t expected_q [$];
  bit      no_gaps;
  int      errors = 0;
  int      sent_n = 0;
  int      recv_n = 0;
  int      quiet = 0;
  int      hold = 0;
  int      stall_n = 0;
  bit      calm = 1'b0;
  int      idle_cycles = 0;
  int      total_items, exec_items;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 32'(shadow_mem[16'(a + i)]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_wr(logic [31:0] a, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) shadow_mem[16'(a + i)] = v[8*i +: 8];
  endfunction

  function automatic logic [31:0] sext(logic [31:0] v, int bits);
    return $unsigned($signed(v << (32 - bits)) >>> (32 - bits));
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, bit sub, bit sra,
                                         logic [31:0] a, logic [31:0] b, output bit ok);
    ok = 1'b1;
    case (f3)
      3'd0: return sub ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd4: return a ^ b;
      3'd5: return sra ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      3'd7: return a & b;
      default: begin
        ok = 1'b0;
        return '0;
      end
    endcase
  endfunction

  function automatic bit is_legal(logic [31:0] ins);
    logic [2:0] f3;
    f3 = ins[14:12];
    case (ins[6:0])
      OPC_IMM, OPC_REG: return !(f3 == 3'd2 || f3 == 3'd3);
      OPC_LUI, OPC_JAL, OPC_JALR, OPC_HALT: return 1'b1;
      OPC_BRANCH: return f3 inside {3'd0, 3'd1, 3'd4, 3'd5};
      OPC_LOAD, OPC_STORE: return f3 <= 3'd2;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t core_step(logic [1:0] req, logic [15:0] addr, logic [31:0] data);
    result_t r;
    logic [31:0] ins, a, b, immi, imms, nxt, res;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [4:0] rdi;
    bit alt, wr, ok, take;
    r = '0;
    if (req == REQ_WRITE) begin
      mem_wr({16'd0, addr}, data, 4);
    end else if (req == REQ_READ) begin
      r.read_data = mem_rd({16'd0, addr}, 4);
    end else if (req == REQ_EXEC && !shadow_halt) begin
      if (shadow_pc == {16'd0, shadow_trap}) begin
        shadow_halt = 1'b1;
      end else begin
        ins = mem_rd(shadow_pc, 4);
        opc = ins[6:0];
        f3 = ins[14:12];
        rdi = ins[11:7];
        a = shadow_regs[ins[19:15]];
        b = shadow_regs[ins[24:20]];
        alt = ins[31:25] != 7'd0;
        immi = sext({20'd0, ins[31:20]}, 12);
        imms = sext({20'd0, ins[31:25], ins[11:7]}, 12);
        nxt = shadow_pc + 4;
        res = '0;
        wr = 1'b0;
        ok = 1'b1;
        case (opc)
          OPC_IMM: begin
            res = alu_op(f3, 1'b0, alt, a,
                         (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins[24:20]} : immi, ok);
            wr = 1'b1;
          end
          OPC_REG: begin
            res = alu_op(f3, alt, alt, a, b, ok);
            wr = 1'b1;
          end
          OPC_LUI: begin
            res = {ins[31:12], 12'd0};
            wr = 1'b1;
          end
          OPC_JAL: begin
            res = nxt;
            nxt = shadow_pc + sext({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
            wr = 1'b1;
          end
          OPC_JALR: begin
            res = nxt;
            nxt = (a + immi) & ~32'd1;
            wr = 1'b1;
          end
          OPC_BRANCH: begin
            case (f3)
              3'd0: take = a == b;
              3'd1: take = a != b;
              3'd4: take = $signed(a) < $signed(b);
              3'd5: take = !($signed(a) < $signed(b));
              default: begin
                take = 1'b0;
                ok = 1'b0;
              end
            endcase
            if (take)
              nxt = shadow_pc + sext({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
          end
          OPC_LOAD: begin
            case (f3)
              3'd0: res = sext(mem_rd(a + immi, 1), 8);
              3'd1: res = sext(mem_rd(a + immi, 2), 16);
              3'd2: res = mem_rd(a + immi, 4);
              default: ok = 1'b0;
            endcase
            wr = 1'b1;
          end
          OPC_STORE: begin
            if (f3 > 3'd2) ok = 1'b0;
            else mem_wr(a + imms, b, 1 << f3);
          end
          OPC_HALT: begin
            rdi = HALT_LINK_REG;
            res = shadow_pc;
            nxt = {16'd0, shadow_trap};
            wr = 1'b1;
          end
          default: ok = 1'b0;
        endcase
        if (ok) begin
          if (wr && rdi != 5'd0) begin
            shadow_regs[rdi] = res;
            r.rd_written = 1'b1;
            r.rd_index = rdi;
            r.rd_value = res;
          end
          shadow_pc = nxt;
          shadow_retired++;
        end else begin
          shadow_halt = 1'b1;
          shadow_illegal = 1'b1;
        end
      end
    end
    r.pc_value = shadow_pc;
    r.halted = shadow_halt;
    r.illegal = shadow_illegal;
    r.retired_count = shadow_retired;
    return r;
  endfunction

  function automatic void push_item(logic [1:0] req, logic [15:0] addr, logic [31:0] data);
    pend_t p;
    p.is_cfg = 1'b0;
    p.kind = req;
    p.addr = addr;
    p.data = data;
    p.gap = no_gaps ? 0 : $urandom_range(0, 7);
    stim_q.push_back(p);
    expected_q.push_back(core_step(req, addr, data));
    if (req == REQ_EXEC) exec_items++;
  endfunction

  function automatic void push_cfg(logic [1:0] idx, logic [15:0] val);
    pend_t p;
    p.is_cfg = 1'b1;
    p.kind = idx;
    p.addr = val;
    p.data = '0;
    p.gap = 0;
    stim_q.push_back(p);
    if (idx == CFG_CODE_BASE) begin
      shadow_base = val;
      shadow_pc = {16'd0, val};
    end else begin
      shadow_trap = val;
    end
  endfunction

  function automatic logic [31:0] make_insn(int k, bit rd_zero);
    logic [31:0] w;
    logic [4:0] rd;
    logic [2:0] f3;
    w = $urandom;
    rd = rd_zero ? 5'd0 : 5'($urandom_range(0, 31));
    case (k)
      0, 1: begin
        case ($urandom_range(0, 5))
          0: f3 = 3'd0;
          1: f3 = 3'd1;
          2: f3 = 3'd4;
          3: f3 = 3'd5;
          4: f3 = 3'd6;
          default: f3 = 3'd7;
        endcase
        if ($urandom_range(0, 1) == 0) w[31:25] = '0;
        return {w[31:15], f3, rd, (k == 0) ? OPC_IMM : OPC_REG};
      end
      2: return {w[31:12], rd, OPC_LUI};
      3: return {w[31:12], rd, OPC_JAL};
      4: return {w[31:12], rd, OPC_JALR};
      5: begin
        case ($urandom_range(0, 3))
          0: f3 = 3'd0;
          1: f3 = 3'd1;
          2: f3 = 3'd4;
          default: f3 = 3'd5;
        endcase
        return {w[31:15], f3, w[11:7], OPC_BRANCH};
      end
      6: return {w[31:15], 3'($urandom_range(0, 2)), rd, OPC_LOAD};
      7: return {w[31:15], 3'($urandom_range(0, 2)), w[11:7], OPC_STORE};
      default: return {w[31:7], OPC_HALT};
    endcase
  endfunction

  function automatic void place_and_run(int k, bit rd_zero);
    push_item(REQ_WRITE, shadow_pc[15:0], make_insn(k, rd_zero));
    push_item(REQ_EXEC, 16'($urandom), $urandom);
  endfunction

  function automatic void run_phase(int n);
    int r, k;
    for (int i = 0; i < n; i++) begin
      if (shadow_pc == {16'd0, shadow_trap}) break;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = $urandom_range(0, 8);
        if (k == 8 && $urandom_range(0, 9) != 0) k = 0;
        place_and_run(k, 1'b0);
      end else if (r < 70) begin
        if (!is_legal(mem_rd(shadow_pc, 4)))
          push_item(REQ_WRITE, shadow_pc[15:0], make_insn($urandom_range(0, 7), 1'b0));
        push_item(REQ_EXEC, 16'($urandom), $urandom);
      end else if (r < 80) begin
        push_item(REQ_READ, ($urandom_range(0, 1) == 0) ? shadow_pc[15:0] + 16'($urandom_range(0, 8))
                                                        : 16'($urandom), $urandom);
      end else if (r < 92) begin
        push_item(REQ_WRITE, 16'($urandom), $urandom);
      end else begin
        push_item(2'd3, 16'($urandom), $urandom);
      end
    end
  endfunction

  function automatic logic [31:0] make_illegal();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0: w[6:0] = 7'h00;
      1: begin
        w[14:12] = 3'd2 + 3'($urandom_range(0, 1));
        w[6:0] = ($urandom_range(0, 1) == 0) ? OPC_IMM : OPC_REG;
      end
      2: begin
        w[14:12] = 3'd6 + 3'($urandom_range(0, 1));
        w[6:0] = OPC_BRANCH;
      end
      3: begin
        w[14:12] = 3'($urandom_range(3, 7));
        w[6:0] = OPC_LOAD;
      end
      default: begin
        w[14:12] = 3'($urandom_range(3, 7));
        w[6:0] = OPC_STORE;
      end
    endcase
    return w;
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    logic v, cv;
    pend_t p;
    v = s_axis_tvalid;
    cv = cfg_valid_i;
    if (v && s_axis_tready) begin
      v = 1'b0;
      sent_n = sent_n + 1;
    end
    if (cv && cfg_ready_o) cv = 1'b0;
    if (rst_ni && !v && !cv) begin
      if (hold != 0) begin
        hold <= hold - 1;
      end else if (stim_q.size() != 0) begin
        p = stim_q[0];
        if (!p.is_cfg) begin
          v = 1'b1;
          s_axis_tuser <= p.kind;
          s_axis_tdata <= {p.data, p.addr};
          hold <= p.gap;
          void'(stim_q.pop_front());
        end else if (sent_n == recv_n && quiet >= 6) begin
          cv = 1'b1;
          cfg_index_i <= p.kind;
          cfg_data_i <= p.addr;
          void'(stim_q.pop_front());
        end
      end
    end
    s_axis_tvalid <= v;
    cfg_valid_i <= cv;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Monitor.
  always @(posedge clk_i) begin
    result_t got, want;
    int s;
    s = stall_n;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("pc_value", want.pc_value, got.pc_value);
        check_field("halted", want.halted, got.halted);
        check_field("illegal", want.illegal, got.illegal);
        check_field("rd_written", want.rd_written, got.rd_written);
        check_field("rd_index", want.rd_index, got.rd_index);
        check_field("rd_value", want.rd_value, got.rd_value);
        check_field("retired_count", want.retired_count, got.retired_count);
      end
      recv_n <= recv_n + 1;
      quiet <= 0;
      if (recv_n % 80 == 79) calm = !calm;
      s = calm ? 0 : $urandom_range(0, 7);
    end else begin
      if (s > 0) s--;
      quiet <= quiet + 1;
    end
    stall_n <= s;
    m_axis_tready <= rst_ni && s == 0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cb, tv;
    for (int i = 0; i < 65536; i++) shadow_mem[i] = '0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    shadow_base = CODE_BASE_RST;
    shadow_trap = TRAP_VEC_RST;
    shadow_pc = {16'd0, CODE_BASE_RST};
    shadow_halt = 1'b0;
    shadow_illegal = 1'b0;
    shadow_retired = '0;
    exec_items = 0;
    no_gaps = 1'b0;

    push_item(REQ_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(REQ_READ, 16'hFFFF, '0);
    push_item(REQ_READ, 16'hFFFE, 32'hFFFF_FFFF);
    push_item(REQ_READ, 16'h0000, '0);
    push_item(2'd3, 16'hFFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) place_and_run(k, 1'b0);
    place_and_run(1, 1'b1);
    run_phase(45);
    if (shadow_pc != {16'd0, shadow_trap}) place_and_run(8, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin cb = 16'h0000; tv = 16'hFFFF; end
        1: begin cb = 16'hFFFF; tv = 16'h0000; end
        2: begin cb = 16'hFFFE; tv = 16'hFFFF; end
        default: begin
          cb = 16'($urandom);
          tv = 16'($urandom);
          if (tv == cb) tv = tv ^ 16'h1;
        end
      endcase
      no_gaps = ph[0];
      push_cfg(CFG_CODE_BASE, cb);
      push_cfg(CFG_TRAP_VEC, tv);
      run_phase(50);
    end

    // An illegal encoding stops the core for good; the last items then see it stopped.
    if (shadow_pc == {16'd0, shadow_trap}) push_cfg(CFG_CODE_BASE, shadow_trap + 16'd64);
    push_item(REQ_WRITE, shadow_pc[15:0], make_illegal());
    push_item(REQ_EXEC, '0, '0);
    push_item(REQ_EXEC, '1, '1);
    push_item(REQ_READ, shadow_pc[15:0], '0);
    total_items = expected_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() != 0 || recv_n != total_items) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d items (%0d instruction steps) over eight base/trap settings,",
             total_items, exec_items);
    $display("with host reads and writes, random stalls and a final illegal stop.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
